### sv/bond_orientation_histogram_unit_defines.svh
// Assertion macros for the bond orientation histogram unit
`ifndef BOND_ORIENTATION_HISTOGRAM_UNIT_DEFINES_SVH
`define BOND_ORIENTATION_HISTOGRAM_UNIT_DEFINES_SVH
`ifndef SYNTH
`define BOH_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BOH_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BOH_ASSERT_IMP(label, clk, rst_n, a, c)
`define BOH_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### sv/boh_pkg.sv
// Package: types, constants and tables of the bond orientation histogram unit
`default_nettype none
package boh_pkg;
    localparam int MAX_SLOTS    = 64;
    localparam int COUNT_WIDTH  = 32;
    localparam int BETA_DIM     = 2 * MAX_SLOTS;
    localparam int TABLE_SIZE   = MAX_SLOTS * BETA_DIM;
    localparam int NUM_TABLES   = 3;
    localparam int STORE_DEPTH  = NUM_TABLES * TABLE_SIZE;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int AB_W         = $clog2(MAX_SLOTS);
    localparam int BB_W         = $clog2(BETA_DIM);
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CW           = 36;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [0:0] OP_ACC  = 1'b0;
    localparam logic [0:0] OP_READ = 1'b1;
    localparam logic [0:0] REG_CUTOFF = 1'b0;
    localparam logic [0:0] REG_SLOTS  = 1'b1;

    typedef struct packed {
        logic [0:0]  opcode;
        logic signed [15:0] disp_x;
        logic signed [15:0] disp_y;
        logic signed [15:0] disp_z;
        logic [1:0]  first_type;
        logic [1:0]  second_type;
        logic [5:0]  read_alpha_bin;
        logic [6:0]  read_beta_bin;
        logic [1:0]  read_table;
    } t_in_item;

    typedef struct packed {
        logic [0:0] counted;
        logic [5:0] alpha_bin;
        logic [6:0] beta_bin;
        logic [31:0] bin_count;
    } t_out_item;

    // one bit wider than a displacement: a flipped -32768 becomes +32768
    typedef struct packed {
        logic              start;
        logic signed [16:0] x;
        logic signed [16:0] y;
    } t_cordic_req;

    typedef struct packed {
        logic        done;
        logic [31:0] angle;
    } t_cordic_rsp;

    function automatic logic [31:0] arctan(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

### sv/boh_ram.sv
// Generic single-port RAM with registered read
`default_nettype none
module boh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### sv/boh_cordic.sv
// Iterative CORDIC vectoring unit: one rotation step per cycle
`default_nettype none
module boh_cordic (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  boh_pkg::t_cordic_req   i_req,
    output boh_pkg::t_cordic_rsp   o_rsp
);
    import boh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic signed [CW-1:0] r_cx, r_cy;
    logic [31:0]         r_ang;
    logic                r_ypos;
    logic signed [CW-1:0] w_sx, w_sy;
    logic [31:0]         w_d, w_fin;

    assign w_sx = r_cx >>> r_step;
    assign w_sy = r_cy >>> r_step;

    // clamp into the half circle in which the vector lies
    always_comb begin
        w_d = r_ang - (r_ypos ? 32'h0 : HALF_TURN);
        if (w_d > HALF_TURN) begin
            w_d = (w_d >= HALF_TURN + QUARTER_TURN) ? 32'h0 : HALF_TURN;
        end
        w_fin = w_d + (r_ypos ? 32'h0 : HALF_TURN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            o_rsp.done <= 1'b0;
        end else begin
            o_rsp.done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_ypos <= (i_req.y > 0);
                        r_step <= '0;
                        if (i_req.y == 0) begin
                            o_rsp.angle <= (i_req.x < 0) ? HALF_TURN : 32'h0;
                            o_rsp.done  <= 1'b1;
                        end else if (i_req.x == 0) begin
                            o_rsp.angle <= (i_req.y > 0) ? QUARTER_TURN
                                                         : HALF_TURN + QUARTER_TURN;
                            o_rsp.done  <= 1'b1;
                        end else if (i_req.x < 0) begin
                            r_cx  <= -{{(CW-33){i_req.x[16]}}, i_req.x, 16'h0};
                            r_cy  <= -{{(CW-33){i_req.y[16]}}, i_req.y, 16'h0};
                            r_ang <= HALF_TURN;
                            r_state <= S_RUN;
                        end else begin
                            r_cx  <= {{(CW-33){i_req.x[16]}}, i_req.x, 16'h0};
                            r_cy  <= {{(CW-33){i_req.y[16]}}, i_req.y, 16'h0};
                            r_ang <= 32'h0;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_cy > 0) begin
                        r_cx  <= r_cx + w_sy;
                        r_cy  <= r_cy - w_sx;
                        r_ang <= r_ang + arctan(r_step);
                    end else begin
                        r_cx  <= r_cx - w_sy;
                        r_cy  <= r_cy + w_sx;
                        r_ang <= r_ang - arctan(r_step);
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    o_rsp.angle <= w_fin;
                    o_rsp.done  <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/bond_orientation_histogram_unit.sv
// Top level: bond orientation histogram with iterative CORDIC and histogram RAM
// Flow: a bond needs two CORDIC runs on the one shared unit, then bin, RAM read and write;
// on the axes the runs finish early, a bond outside cutoff skips them, a read only reads.
// Throughput: one item at a time; the next input transfer comes in the cycle after the
// result transfer at the earliest.
// Reset: synchronous, active low; then a pass clears every bin (no items).
`default_nettype none
`include "bond_orientation_histogram_unit_defines.svh"
module bond_orientation_histogram_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  boh_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  wire                 i_ready,
    output boh_pkg::t_out_item  o_item,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [0:0]          i_cfg_index,
    input  wire  [31:0]         i_cfg_data
);
    import boh_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CUT, S_ALPHA, S_WA, S_BETA, S_WB,
        S_BIN, S_RD, S_RDW, S_WR, S_OUT
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr;
    logic [31:0]         r_cut;
    logic [6:0]          r_slots;
    t_in_item            r_it;
    logic signed [16:0]  r_x, r_y, r_z;
    logic [33:0]         r_r2;
    logic [31:0]         r_aang, r_bang;
    logic [AB_W-1:0]     r_ab;
    logic [BB_W-1:0]     r_bb;
    logic [1:0]          r_tab;
    logic                r_hit;
    t_cordic_req         r_req;
    t_cordic_rsp         w_rsp;
    logic                r_we;
    logic [ADDR_W-1:0]   r_addr;
    logic [COUNT_WIDTH-1:0] r_wd, w_rd;
    logic [6:0]          w_s;
    logic [39:0]         w_ap, w_bp;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);

    // effective slot count: zero acts as one, clip at the maximum
    assign w_s = (r_slots == 7'd0) ? 7'd1 :
                 (r_slots > 7'(MAX_SLOTS)) ? 7'(MAX_SLOTS) : r_slots;
    assign w_ap = {33'h0, w_s} * {8'h0, r_aang};
    assign w_bp = {33'h0, w_s} * {8'h0, r_bang};

    boh_cordic u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_rsp  (w_rsp)
    );

    boh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_addr (r_addr),
        .i_wdata(r_wd),
        .o_rdata(w_rd)
    );

    // configuration writes land whenever they are offered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut   <= 32'd4194304;
            r_slots <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CUTOFF: r_cut   <= i_cfg_data;
                REG_SLOTS:  r_slots <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_we      <= 1'b0;
            o_valid   <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_we        <= 1'b0;
            r_req.start <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    // sweep zero through every bin
                    r_we   <= 1'b1;
                    r_addr <= r_clr;
                    r_wd   <= '0;
                    r_clr  <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(STORE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_it <= i_item;
                        // squared length, summed exactly
                        r_r2 <= 34'(32'(i_item.disp_x * i_item.disp_x))
                              + 34'(32'(i_item.disp_y * i_item.disp_y))
                              + 34'(32'(i_item.disp_z * i_item.disp_z));
                        // flip into dy >= 0, one bit wider so -32768 survives
                        if (i_item.disp_y < 0) begin
                            r_x <= -17'(i_item.disp_x);
                            r_y <= -17'(i_item.disp_y);
                            r_z <= -17'(i_item.disp_z);
                        end else begin
                            r_x <= 17'(i_item.disp_x);
                            r_y <= 17'(i_item.disp_y);
                            r_z <= 17'(i_item.disp_z);
                        end
                        // a read issues its RAM address straight away
                        if (i_item.opcode == OP_READ) begin
                            r_addr <= ADDR_W'({i_item.read_table, i_item.read_alpha_bin,
                                               i_item.read_beta_bin});
                        end
                        r_state <= (i_item.opcode == OP_READ) ? S_RD : S_CUT;
                    end
                end
                S_CUT: begin
                    if (r_r2 >= {2'b0, r_cut}) begin
                        o_item  <= '0;
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_req.start <= 1'b1;
                        r_req.x     <= r_x;
                        r_req.y     <= r_y;
                        r_state     <= S_ALPHA;
                    end
                end
                S_ALPHA: begin
                    if (w_rsp.done) begin
                        r_aang      <= w_rsp.angle;
                        r_req.start <= 1'b1;
                        r_req.x     <= r_x;
                        r_req.y     <= r_z;
                        r_state     <= S_BETA;
                    end
                end
                S_BETA: begin
                    if (w_rsp.done) begin
                        r_bang  <= w_rsp.angle;
                        r_state <= S_BIN;
                    end
                end
                S_BIN: begin
                    r_ab <= (w_ap[38:31] > {1'b0, w_s - 7'd1}) ? AB_W'(w_s - 7'd1)
                                                               : AB_W'(w_ap[38:31]);
                    r_bb <= (w_bp[38:31] > {w_s, 1'b0} - 8'd1)
                          ? BB_W'({w_s, 1'b0} - 8'd1) : BB_W'(w_bp[38:31]);
                    if (r_it.first_type == 2'd0 && r_it.second_type == 2'd0) begin
                        r_tab <= 2'd0; r_hit <= 1'b1;
                    end else if ((r_it.first_type == 2'd0 && r_it.second_type == 2'd1) ||
                                 (r_it.first_type == 2'd1 && r_it.second_type == 2'd0)) begin
                        r_tab <= 2'd1; r_hit <= 1'b1;
                    end else if (r_it.first_type == 2'd1 && r_it.second_type == 2'd1) begin
                        r_tab <= 2'd2; r_hit <= 1'b1;
                    end else begin
                        r_tab <= 2'd3; r_hit <= 1'b0;
                    end
                    r_state <= S_WA;
                end
                S_WA: begin
                    // issue the RAM read of the target bin
                    r_addr  <= ADDR_W'({r_tab, r_ab, r_bb});
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_hit) begin
                        r_we <= 1'b1;
                        r_wd <= (&w_rd) ? w_rd : w_rd + 1'b1;
                    end
                    o_item.counted   <= r_hit;
                    o_item.alpha_bin <= r_ab;
                    o_item.beta_bin  <= r_bb;
                    o_item.bin_count <= '0;
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_RD: begin
                    // hold while the RAM read completes
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    o_item.counted   <= 1'b0;
                    o_item.alpha_bin <= r_it.read_alpha_bin;
                    o_item.beta_bin  <= r_it.read_beta_bin;
                    r_state <= S_OUT;
                    o_valid <= 1'b1;
                    if (r_it.read_table != 2'd3 && {1'b0, r_it.read_alpha_bin} < w_s
                        && {1'b0, r_it.read_beta_bin} < {w_s, 1'b0}) begin
                        o_item.bin_count <= w_rd;
                    end else begin
                        o_item.bin_count <= '0;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BOH_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !o_valid)
    `BOH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `BOH_ASSERT_IMP(a_count_acc, i_clk, i_rst_n, o_valid && o_item.counted, o_item.bin_count == 0)
endmodule
`default_nettype wire
